// ===== sv/cbs_pkg.sv =====
// shared types, constants and the microcode table of the cubic b-spline evaluator
// no dependencies; used by cbs_seq, cbs_dp and cubic_bspline_point_eval_top
package cbs_pkg;

    localparam int CBS_STEPS = 100;     // default samples per segment
    localparam int CBS_PW    = 16;      // coordinate width
    localparam int CBS_KW    = 7;       // sample index width
    localparam int CBS_DEPTH = 4;       // control points in the window
    localparam int CBS_QW    = CBS_PW;  // quotient bits out of the divider
    localparam int CBS_SEQW  = 5;       // step counter width

    // program addresses
    localparam logic [CBS_SEQW-1:0] STEP_IDLE = CBS_SEQW'(0);
    localparam logic [CBS_SEQW-1:0] STEP_CHK  = CBS_SEQW'(1);
    localparam logic [CBS_SEQW-1:0] STEP_FIN  = CBS_SEQW'(20);

    typedef enum logic [2:0] {
        C_NEXT       = 3'd0,
        C_WAIT_START = 3'd1,
        C_SKIP_SHORT = 3'd2,
        C_WAIT_OUT   = 3'd3
    } t_cond;

    typedef enum logic [2:0] {
        A_K  = 3'd0,
        A_U  = 3'd1,
        A_P  = 3'd2,
        A_K2 = 3'd3,
        A_K3 = 3'd4,
        A_W0 = 3'd5,
        A_W1 = 3'd6,
        A_W2 = 3'd7
    } t_asel;

    typedef enum logic [2:0] {
        B_K  = 3'd0,
        B_U  = 3'd1,
        B_KM = 3'd2,
        B_PX = 3'd3,
        B_PY = 3'd4
    } t_bsel;

    typedef enum logic [3:0] {
        WR_NONE     = 4'd0,
        WR_K2       = 4'd1,
        WR_K3       = 4'd2,
        WR_W0       = 4'd3,
        WR_W1       = 4'd4,
        WR_W2       = 4'd5,
        WR_ACCX_LD  = 4'd6,
        WR_ACCX_ADD = 4'd7,
        WR_ACCY_LD  = 4'd8,
        WR_ACCY_ADD = 4'd9
    } t_wr;

    typedef enum logic [2:0] {
        D_NONE = 3'd0,
        D_INIT = 3'd1,
        D_EST  = 3'd2,
        D_REM  = 3'd3,
        D_FIX  = 3'd4
    } t_dop;

    typedef struct packed {
        logic                idle;
        t_cond               cond;
        logic [CBS_SEQW-1:0] target;
        t_asel               asel;
        t_bsel               bsel;
        logic [1:0]          pidx;
        t_wr                 wr;
        t_dop                dop;
        logic                out_wr;
    } t_uword;

    typedef struct packed {
        logic start;
        logic short_win;
        logic out_free;
    } t_stat;

    function automatic t_uword cbs_ucode(input logic [CBS_SEQW-1:0] step);
        t_uword uw;
        uw.idle   = 1'b0;
        uw.cond   = C_NEXT;
        uw.target = STEP_IDLE;
        uw.asel   = A_K;
        uw.bsel   = B_K;
        uw.pidx   = 2'd0;
        uw.wr     = WR_NONE;
        uw.dop    = D_NONE;
        uw.out_wr = 1'b0;
        case (step)
            5'd0: begin
                uw.idle = 1'b1;
                uw.cond = C_WAIT_START;
            end
            5'd1: begin
                // k*k; a short window goes straight to the result step
                uw.cond   = C_SKIP_SHORT;
                uw.target = STEP_FIN;
            end
            5'd2: begin
                uw.wr   = WR_K2;
                uw.asel = A_P;
            end
            5'd3: begin
                uw.wr   = WR_K3;
                uw.asel = A_U;
                uw.bsel = B_U;
            end
            5'd4: begin
                uw.asel = A_P;
                uw.bsel = B_U;
            end
            5'd5: begin
                uw.wr   = WR_W0;
                uw.asel = A_K2;
                uw.bsel = B_KM;
            end
            5'd6: begin
                uw.wr = WR_W1;
            end
            5'd7: begin
                uw.wr   = WR_W2;
                uw.asel = A_W0;
                uw.bsel = B_PX;
                uw.pidx = 2'd0;
            end
            5'd8: begin
                uw.wr   = WR_ACCX_LD;
                uw.asel = A_W1;
                uw.bsel = B_PX;
                uw.pidx = 2'd1;
            end
            5'd9: begin
                uw.wr   = WR_ACCX_ADD;
                uw.asel = A_W2;
                uw.bsel = B_PX;
                uw.pidx = 2'd2;
            end
            5'd10: begin
                uw.wr   = WR_ACCX_ADD;
                uw.asel = A_K3;
                uw.bsel = B_PX;
                uw.pidx = 2'd3;
            end
            5'd11: begin
                uw.wr   = WR_ACCX_ADD;
                uw.asel = A_W0;
                uw.bsel = B_PY;
                uw.pidx = 2'd0;
            end
            5'd12: begin
                uw.wr   = WR_ACCY_LD;
                uw.asel = A_W1;
                uw.bsel = B_PY;
                uw.pidx = 2'd1;
            end
            5'd13: begin
                uw.wr   = WR_ACCY_ADD;
                uw.asel = A_W2;
                uw.bsel = B_PY;
                uw.pidx = 2'd2;
            end
            5'd14: begin
                uw.wr   = WR_ACCY_ADD;
                uw.asel = A_K3;
                uw.bsel = B_PY;
                uw.pidx = 2'd3;
            end
            5'd15: begin
                uw.wr = WR_ACCY_ADD;
            end
            5'd16: begin
                uw.dop = D_INIT;
            end
            5'd17: begin
                uw.dop = D_EST;
            end
            5'd18: begin
                uw.dop = D_REM;
            end
            5'd19: begin
                uw.dop = D_FIX;
            end
            5'd20: begin
                uw.out_wr = 1'b1;
                uw.cond   = C_WAIT_OUT;
                uw.target = STEP_IDLE;
            end
            default: begin
                uw.cond   = C_WAIT_OUT;
                uw.target = STEP_IDLE;
            end
        endcase
        return uw;
    endfunction

endpackage

// ===== sv/cbs_seq.sv =====
// microcode sequencer: step counter and program table
// depends on cbs_pkg
module cbs_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cbs_pkg::t_stat  i_stat,
    output cbs_pkg::t_uword o_uw
);
    import cbs_pkg::*;

    logic [CBS_SEQW-1:0] r_step, n_step;
    t_uword              uw;

    assign uw   = cbs_ucode(r_step);
    assign o_uw = uw;

    always_comb begin
        n_step = CBS_SEQW'(r_step + 1'b1);
        case (uw.cond)
            C_NEXT: begin
                n_step = CBS_SEQW'(r_step + 1'b1);
            end
            C_WAIT_START: begin
                n_step = i_stat.start ? CBS_SEQW'(r_step + 1'b1) : r_step;
            end
            C_SKIP_SHORT: begin
                n_step = i_stat.short_win ? uw.target : CBS_SEQW'(r_step + 1'b1);
            end
            C_WAIT_OUT: begin
                n_step = i_stat.out_free ? uw.target : r_step;
            end
            default: begin
                n_step = STEP_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ===== sv/cbs_dp.sv =====
// datapath: shared multiplier, basis weights, accumulators and two-lane reciprocal divider
// depends on cbs_pkg; driven by the control word of cbs_seq
module cbs_dp #(
    parameter int STEPS = cbs_pkg::CBS_STEPS
) (
    input  logic                               i_clk,
    input  cbs_pkg::t_uword                    i_uw,
    input  logic                               i_load,
    input  logic [cbs_pkg::CBS_KW-1:0]         i_sample_index,
    input  logic signed [cbs_pkg::CBS_PW-1:0]  i_win_x [cbs_pkg::CBS_DEPTH],
    input  logic signed [cbs_pkg::CBS_PW-1:0]  i_win_y [cbs_pkg::CBS_DEPTH],
    output logic signed [cbs_pkg::CBS_PW-1:0]  o_x,
    output logic signed [cbs_pkg::CBS_PW-1:0]  o_y
);
    import cbs_pkg::*;

    localparam longint S   = longint'(STEPS);
    localparam longint S3  = S * S * S;
    localparam longint DEN = 6 * S3;
    localparam longint C4  = 4 * S3;
    localparam longint DV  = 2 * DEN;
    localparam int SW   = $clog2(STEPS + 1);
    localparam int WW   = $clog2(DEN + 1);
    localparam int AW   = WW + 1;
    localparam int KMW  = $clog2(6 * STEPS + 1) + 1;
    localparam int BW   = (KMW > CBS_PW) ? KMW : CBS_PW;
    localparam int PW   = AW + BW;
    localparam int RW   = PW + 1;
    // the estimate drops the low TS bits of the magnitude; 2^(TS+2) <= DV
    localparam int TS   = $clog2(DV + 1) - 3;
    localparam int MHW  = RW - TS;
    localparam int FS   = MHW + 2;
    localparam longint RCP = (longint'(1) << (FS + TS)) / DV;
    localparam int RCW  = $clog2(RCP + 1);
    localparam int EW   = MHW + RCW;
    localparam int DVW  = $clog2(DV + 1);
    localparam int QVW  = CBS_QW + DVW;

    logic [CBS_KW-1:0]       r_k;
    logic [SW-1:0]           r_u;
    logic [WW-1:0]           r_k2, r_k3, r_w0, r_w1, r_w2;
    logic signed [PW-1:0]    r_p, r_acc_x, r_acc_y;
    logic [RW-1:0]           r_rx, r_ry;
    logic                    r_neg_x, r_neg_y;
    logic [CBS_QW-1:0]       r_q_x, r_q_y;

    logic [CBS_KW-1:0]       k_clamp;
    logic signed [AW-1:0]    mul_a;
    logic signed [BW-1:0]    mul_b;
    logic signed [BW-1:0]    km;
    logic signed [PW-1:0]    mul_p;
    logic signed [RW-1:0]    num_x, num_y;
    logic [EW-1:0]           est_x, est_y;
    logic [QVW-1:0]          qv_x, qv_y;

    // index beyond the segment end is held at the end point
    always_comb begin
        k_clamp = i_sample_index;
        if (int'(i_sample_index) > STEPS) begin
            k_clamp = CBS_KW'(STEPS);
        end
    end

    assign km = BW'(3 * int'(r_k) - 6 * STEPS);

    always_comb begin
        case (i_uw.asel)
            A_K:     mul_a = AW'(r_k);
            A_U:     mul_a = AW'(r_u);
            A_P:     mul_a = AW'(r_p);
            A_K2:    mul_a = AW'(r_k2);
            A_K3:    mul_a = AW'(r_k3);
            A_W0:    mul_a = AW'(r_w0);
            A_W1:    mul_a = AW'(r_w1);
            A_W2:    mul_a = AW'(r_w2);
            default: mul_a = '0;
        endcase
    end

    always_comb begin
        case (i_uw.bsel)
            B_K:     mul_b = BW'(r_k);
            B_U:     mul_b = BW'(r_u);
            B_KM:    mul_b = km;
            B_PX:    mul_b = BW'(i_win_x[i_uw.pidx]);
            B_PY:    mul_b = BW'(i_win_y[i_uw.pidx]);
            default: mul_b = '0;
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // 2N + D, then sign and magnitude into the divider
    assign num_x = (RW'(r_acc_x) <<< 1) + RW'(DEN);
    assign num_y = (RW'(r_acc_y) <<< 1) + RW'(DEN);

    // quotient estimate from the top bits times the reciprocal of 2D
    assign est_x = EW'(r_rx[RW-1:TS]) * EW'(RCP);
    assign est_y = EW'(r_ry[RW-1:TS]) * EW'(RCP);

    // estimate times 2D, a constant multiply
    assign qv_x = QVW'(r_q_x) * QVW'(DV);
    assign qv_y = QVW'(r_q_y) * QVW'(DV);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_k <= k_clamp;
            r_u <= SW'(STEPS - int'(k_clamp));
        end
        r_p <= mul_p;
        case (i_uw.wr)
            WR_K2:       r_k2    <= WW'(r_p);
            WR_K3:       r_k3    <= WW'(r_p);
            WR_W0:       r_w0    <= WW'(r_p);
            WR_W1:       r_w1    <= WW'(r_p + PW'(C4));
            WR_W2:       r_w2    <= WW'(DEN) - r_w0 - r_w1 - r_k3;
            WR_ACCX_LD:  r_acc_x <= r_p;
            WR_ACCX_ADD: r_acc_x <= r_acc_x + r_p;
            WR_ACCY_LD:  r_acc_y <= r_p;
            WR_ACCY_ADD: r_acc_y <= r_acc_y + r_p;
            default: begin
            end
        endcase
        case (i_uw.dop)
            D_INIT: begin
                r_neg_x <= num_x[RW-1];
                r_neg_y <= num_y[RW-1];
                r_rx    <= num_x[RW-1] ? RW'(-num_x) : RW'(num_x);
                r_ry    <= num_y[RW-1] ? RW'(-num_y) : RW'(num_y);
            end
            D_EST: begin
                r_q_x <= CBS_QW'(est_x >> FS);
                r_q_y <= CBS_QW'(est_y >> FS);
            end
            D_REM: begin
                r_rx <= r_rx - RW'(qv_x);
                r_ry <= r_ry - RW'(qv_y);
            end
            D_FIX: begin
                // estimate is the quotient or one below it
                if (r_rx >= RW'(DV)) begin
                    r_q_x <= CBS_QW'(r_q_x + 1'b1);
                end
                if (r_ry >= RW'(DV)) begin
                    r_q_y <= CBS_QW'(r_q_y + 1'b1);
                end
            end
            default: begin
            end
        endcase
    end

    // truncation toward zero: the magnitude quotient takes the sign back
    assign o_x = r_neg_x ? CBS_PW'(-r_q_x) : CBS_PW'(r_q_x);
    assign o_y = r_neg_y ? CBS_PW'(-r_q_y) : CBS_PW'(r_q_y);

endmodule

// ===== sv/cubic_bspline_point_eval_top.sv =====
// cubic b-spline point evaluator: a push beat gives no result
// evaluate with four points held: steps on one shared multiplier, then the init, estimate,
// remainder and fix steps of the reciprocal divider; the final step registers the result
// once the output is free and goes back to idle; fewer points skip to the final step
// reset clears the sequencer, the point count and the output valid
module cubic_bspline_point_eval_top #(
    parameter int STEPS = cbs_pkg::CBS_STEPS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_req_type,
    input  logic signed [cbs_pkg::CBS_PW-1:0] i_point_x,
    input  logic signed [cbs_pkg::CBS_PW-1:0] i_point_y,
    input  logic [cbs_pkg::CBS_KW-1:0]        i_sample_index,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [cbs_pkg::CBS_PW-1:0] o_curve_x,
    output logic signed [cbs_pkg::CBS_PW-1:0] o_curve_y,
    output logic                              o_point_valid
);
    import cbs_pkg::*;

    localparam int HW = $clog2(CBS_DEPTH + 1);

    logic signed [CBS_PW-1:0] r_win_x [CBS_DEPTH];
    logic signed [CBS_PW-1:0] r_win_y [CBS_DEPTH];
    logic [HW-1:0]            r_held;
    logic                     r_full;
    logic                     r_out_valid;
    logic signed [CBS_PW-1:0] r_out_x, r_out_y;
    logic                     r_out_pv;

    t_uword                   uw;
    t_stat                    stat;
    logic                     take, push, start;
    logic signed [CBS_PW-1:0] dp_x, dp_y;

    assign o_stall = !uw.idle;
    assign take    = i_valid && !o_stall;
    assign push    = take && !i_req_type;
    assign start   = take && i_req_type;

    assign stat.start     = start;
    assign stat.short_win = !r_full;
    assign stat.out_free  = !r_out_valid || !i_stall;

    cbs_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_uw    (uw)
    );

    cbs_dp #(
        .STEPS (STEPS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_uw           (uw),
        .i_load         (start),
        .i_sample_index (i_sample_index),
        .i_win_x        (r_win_x),
        .i_win_y        (r_win_y),
        .o_x            (dp_x),
        .o_y            (dp_y)
    );

    // sliding window, oldest point in entry 0
    always_ff @(posedge i_clk) begin
        if (push) begin
            for (int i = 0; i < CBS_DEPTH - 1; i++) begin
                r_win_x[i] <= r_win_x[i+1];
                r_win_y[i] <= r_win_y[i+1];
            end
            r_win_x[CBS_DEPTH-1] <= i_point_x;
            r_win_y[CBS_DEPTH-1] <= i_point_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_full <= 1'b0;
        end else begin
            if (push && (r_held != HW'(CBS_DEPTH))) begin
                r_held <= HW'(r_held + 1'b1);
            end
            if (start) begin
                r_full <= (r_held == HW'(CBS_DEPTH));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (uw.out_wr && stat.out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.out_wr && stat.out_free) begin
            r_out_x  <= r_full ? dp_x : '0;
            r_out_y  <= r_full ? dp_y : '0;
            r_out_pv <= r_full;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_curve_x     = r_out_x;
    assign o_curve_y     = r_out_y;
    assign o_point_valid = r_out_pv;

    a_invalid_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_point_valid |-> o_curve_x == '0 && o_curve_y == '0)
        else $error("invalid result beat carries a nonzero point");

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= HW'(CBS_DEPTH))
        else $error("point count above window depth");

    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> o_stall)
        else $error("evaluate taken without sequencer leaving idle");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(uw.out_wr))
        else $error("result loaded outside the final program step");

endmodule

// ===== verif/cubic_bspline_point_eval_top_test.sv =====
// testbench for cubic_bspline_point_eval_top: directed and random push/evaluate beats
// checked against an in-bench integer b-spline predictor; needs cbs_pkg and the rtl top
module cubic_bspline_point_eval_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cbs_pkg::*;

    localparam int SEG_STEPS   = CBS_STEPS;
    localparam int ITEM_GOAL   = 1200;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 40;
    localparam int MAX_SHOWN   = 10;

    typedef enum logic {
        REQ_PUSH = 1'b0,
        REQ_EVAL = 1'b1
    } t_req_kind;

    typedef struct {
        t_req_kind                kind;
        logic signed [CBS_PW-1:0] x;
        logic signed [CBS_PW-1:0] y;
        logic [CBS_KW-1:0]        k;
    } t_spline_req;

    typedef struct {
        logic signed [CBS_PW-1:0] x;
        logic signed [CBS_PW-1:0] y;
        logic                     valid;
    } t_curve_point;

    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     i_valid        = 1'b0;
    logic                     o_stall;
    logic                     i_req_type     = 1'b0;
    logic signed [CBS_PW-1:0] i_point_x      = '0;
    logic signed [CBS_PW-1:0] i_point_y      = '0;
    logic [CBS_KW-1:0]        i_sample_index = '0;
    logic                     o_valid;
    logic                     i_stall        = 1'b0;
    logic signed [CBS_PW-1:0] o_curve_x;
    logic signed [CBS_PW-1:0] o_curve_y;
    logic                     o_point_valid;

    // predictor state: entry 0 oldest, last entry newest
    logic signed [CBS_PW-1:0] win_x [CBS_DEPTH];
    logic signed [CBS_PW-1:0] win_y [CBS_DEPTH];
    int                       held = 0;

    t_spline_req  reqs_pending[$];
    t_curve_point points_due[$];
    t_spline_req  nxt;
    t_curve_point want;
    int           items_total  = 0;
    int           reqs_taken   = 0;
    int           mismatches   = 0;
    int           quiet_cycles = 0;
    int           send_idle    = 29;
    int           recv_stall   = 79;

    cubic_bspline_point_eval_top #(
        .STEPS(SEG_STEPS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_sample_index (i_sample_index),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_curve_x      (o_curve_x),
        .o_curve_y      (o_curve_y),
        .o_point_valid  (o_point_valid)
    );

    always #10 i_clk = ~i_clk;

    // exact integer evaluation, weights scaled by 6*steps^3, add one half then truncate
    // toward zero
    function automatic t_curve_point bspline_point(input logic [CBS_KW-1:0] k_in);
        t_curve_point pt;
        longint       s, k, u, d, nx, ny, cx, cy;
        longint       w [CBS_DEPTH];
        pt.x     = '0;
        pt.y     = '0;
        pt.valid = 1'b0;
        if (held < CBS_DEPTH) return pt;
        s = SEG_STEPS;
        k = (k_in > SEG_STEPS) ? s : longint'(k_in);
        u = s - k;
        d = 6 * s * s * s;
        w[0] = u * u * u;
        w[1] = 3 * k * k * k - 6 * k * k * s + 4 * s * s * s;
        w[2] = -3 * k * k * k + 3 * k * k * s + 3 * k * s * s + s * s * s;
        w[3] = k * k * k;
        nx = 0;
        ny = 0;
        for (int i = 0; i < CBS_DEPTH; i++) begin
            nx += w[i] * longint'(win_x[i]);
            ny += w[i] * longint'(win_y[i]);
        end
        cx = (2 * nx + d) / (2 * d);
        cy = (2 * ny + d) / (2 * d);
        pt.x     = cx[CBS_PW-1:0];
        pt.y     = cy[CBS_PW-1:0];
        pt.valid = 1'b1;
        return pt;
    endfunction

    function automatic void add_item(input t_req_kind kind, input logic [CBS_PW-1:0] x,
                                     input logic [CBS_PW-1:0] y, input logic [CBS_KW-1:0] k);
        t_spline_req r;
        r.kind = kind;
        r.x    = x;
        r.y    = y;
        r.k    = k;
        reqs_pending.insert(reqs_pending.size(), r);
    endfunction

    function automatic logic [CBS_PW-1:0] rand_coord();
        case ($urandom_range(7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return CBS_PW'($urandom_range(128) - 64);
            default: return CBS_PW'($urandom);
        endcase
    endfunction

    function automatic logic [CBS_KW-1:0] rand_index();
        // mostly in range, sometimes past the segment end
        if ($urandom_range(9) == 0) return CBS_KW'($urandom_range(127, SEG_STEPS + 1));
        return CBS_KW'($urandom_range(SEG_STEPS));
    endfunction

    // driver: predicts on each accepted beat, then offers the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                if (i_req_type == REQ_PUSH) begin
                    for (int i = 0; i < CBS_DEPTH - 1; i++) begin
                        win_x[i] = win_x[i+1];
                        win_y[i] = win_y[i+1];
                    end
                    win_x[CBS_DEPTH-1] = i_point_x;
                    win_y[CBS_DEPTH-1] = i_point_y;
                    if (held < CBS_DEPTH) held++;
                end else begin
                    points_due.insert(points_due.size(), bspline_point(i_sample_index));
                end
                reqs_taken++;
            end
            if (reqs_taken < items_total / 3) begin
                send_idle  <= 29;
                recv_stall <= 79;
            end else if (reqs_taken < 2 * items_total / 3) begin
                send_idle  <= 79;
                recv_stall <= 29;
            end else begin
                send_idle  <= 0;
                recv_stall <= 0;
            end
            if (!i_valid || !o_stall) begin
                if (reqs_pending.size() != 0 && $urandom_range(99) >= send_idle) begin
                    nxt = reqs_pending.pop_front();
                    i_req_type     <= nxt.kind;
                    i_point_x      <= nxt.x;
                    i_point_y      <= nxt.y;
                    i_sample_index <= nxt.k;
                    i_valid        <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: every result beat against the oldest predicted point
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (points_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("unexpected result beat: x=%0d y=%0d valid=%0b",
                                 o_curve_x, o_curve_y, o_point_valid);
                end else begin
                    want = points_due.pop_front();
                    if (o_curve_x !== want.x || o_curve_y !== want.y
                            || o_point_valid !== want.valid) begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display("mismatch: expected x=%0d y=%0d valid=%0b, got x=%0d y=%0d valid=%0b",
                                     want.x, want.y, want.valid,
                                     o_curve_x, o_curve_y, o_point_valid);
                    end
                end
            end
            i_stall <= ($urandom_range(99) < recv_stall);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(negedge i_clk);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        // too few points: empty, one and three held; ignored fields set
        add_item(REQ_EVAL, 16'sh1234, -16'sd5, 7'd50);
        add_item(REQ_PUSH, 16'sh7fff, 16'sh8000, 7'd127);
        add_item(REQ_EVAL, '0, '0, 7'd0);
        add_item(REQ_PUSH, 16'sh8000, 16'sh7fff, 7'd0);
        add_item(REQ_PUSH, 16'sh7fff, 16'sh7fff, 7'd85);
        add_item(REQ_EVAL, 16'sh7fff, 16'sh8000, 7'd100);
        add_item(REQ_PUSH, 16'sh8000, 16'sh8000, 7'd0);
        // full window: segment ends, index past the end, interior points
        add_item(REQ_EVAL, '0, '0, 7'd0);
        add_item(REQ_EVAL, '0, '0, 7'd100);
        add_item(REQ_EVAL, 16'shffff, 16'shffff, 7'd101);
        add_item(REQ_EVAL, '0, '0, 7'd127);
        add_item(REQ_EVAL, '0, '0, 7'd1);
        add_item(REQ_EVAL, '0, '0, 7'd99);
        add_item(REQ_EVAL, '0, '0, 7'd50);
        // all-max and all-min windows
        repeat (4) add_item(REQ_PUSH, 16'sh7fff, 16'sh7fff, 7'd0);
        add_item(REQ_EVAL, '0, '0, 7'd37);
        repeat (4) add_item(REQ_PUSH, 16'sh8000, 16'sh8000, 7'd0);
        add_item(REQ_EVAL, '0, '0, 7'd100);

        // mostly runs of pushes followed by samples on the new segment, some lone beats
        while (reqs_pending.size() < ITEM_GOAL) begin
            if ($urandom_range(19) == 0) begin
                add_item(t_req_kind'($urandom_range(1)), rand_coord(), rand_coord(),
                         CBS_KW'($urandom));
            end else begin
                repeat ($urandom_range(4, 1))
                    add_item(REQ_PUSH, rand_coord(), rand_coord(), CBS_KW'($urandom));
                repeat ($urandom_range(5, 1))
                    add_item(REQ_EVAL, rand_coord(), rand_coord(), rand_index());
            end
        end
        items_total = reqs_pending.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk); while (reqs_pending.size() != 0 || i_valid);
        while (points_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
